@@ hdl/dscr_pkg.sv @@
// Package for DIN sync clock recovery: payload types, opcodes, register
// indexes and tempo constants. No dependencies.
`default_nettype none
package dscr_pkg;
    localparam int CfgWidth = 24;
    localparam int CfgIdxWidth = 3;

    localparam logic [CfgIdxWidth-1:0] REG_ENABLE  = 3'd0;
    localparam logic [CfgIdxWidth-1:0] REG_MIN     = 3'd1;
    localparam logic [CfgIdxWidth-1:0] REG_MAX     = 3'd2;
    localparam logic [CfgIdxWidth-1:0] REG_LOCK    = 3'd3;
    localparam logic [CfgIdxWidth-1:0] REG_TIMEOUT = 3'd4;

    localparam logic [1:0] OP_EDGE    = 2'd0;
    localparam logic [1:0] OP_RUN     = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_LOCK = 2'd1;
    localparam logic [1:0] EV_LOST = 2'd2;

    localparam logic [16:0] TEMPO_MIN   = 17'd7680;
    localparam logic [16:0] TEMPO_MAX   = 17'd76800;
    localparam logic [16:0] TEMPO_RESET = 17'd30720;
    localparam logic [33:0] TEMPO_NUM   = 34'd15360000000;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [47:0] timestamp_us;
        logic        run_level;
    } in_item_t;

    typedef struct packed {
        logic [16:0] tempo_q8;
        logic        locked;
        logic        running;
        logic [31:0] pulse_total;
        logic [4:0]  phase_step;
        logic [1:0]  event_code;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input and its delta
        logic sort_step; // one pass step of selection of median
        logic div_start;
        logic div_step;
        logic finish;    // commit state and form result
    } dscr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_tempo; // edge stored, fill>=2
        logic sort_done;
        logic div_done;
    } dscr_sts_t;
endpackage
`default_nettype wire

@@ hdl/din_sync_clock_recovery_core.sv @@
// Top level of DIN sync clock recovery: joins controller and datapath.
// Depends on dscr_pkg, dscr_ctrl, dscr_datapath.
//
//  channel | ports                       | payload
//  input   | s_valid / s_ready           | s_data  (in_item_t)
//  result  | m_valid / m_ready           | m_data  (out_item_t)
//  config  | cfg_we, cfg_index, cfg_data | 24-bit write data
//
// One item at a time. Timeout, run and non-updating edge events pass the
// EVAL and DONE states from transfer to result; a clock edge that updates
// tempo also passes the counting median search (SORT) and the bit-serial
// divider (DIV) between them. Reset is synchronous; a waiting result holds
// input.
`default_nettype none
module din_sync_clock_recovery_core #(
    parameter int WINDOW = 8,
    parameter int PPQN = 24,
    parameter int TIME_BITS = 48
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [dscr_pkg::CfgIdxWidth-1:0] cfg_index,
    input  wire logic [dscr_pkg::CfgWidth-1:0]    cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire dscr_pkg::in_item_t               s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output dscr_pkg::out_item_t                   m_data
);
    import dscr_pkg::*;

    dscr_cmd_t cmd;
    dscr_sts_t sts;

    dscr_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .cmd, .sts
    );

    dscr_datapath #(.WINDOW(WINDOW), .PPQN(PPQN), .TIME_BITS(TIME_BITS)) u_dp (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .in_time(TIME_BITS'(s_data.timestamp_us)),
        .in_opcode(s_data.opcode),
        .in_level(s_data.run_level),
        .cmd, .sts,
        .result(m_data)
    );
endmodule
`default_nettype wire

@@ hdl/dscr_ctrl.sv @@
// Controller FSM for DIN sync clock recovery.
// Depends on dscr_pkg.
`default_nettype none
module dscr_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output dscr_pkg::dscr_cmd_t    cmd,
    input  wire dscr_pkg::dscr_sts_t sts
);
    import dscr_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EVAL = 5'b00010,
        ST_SORT = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    // accept when idle and output slot is free or leaving
    assign s_ready = (state_reg == ST_IDLE) && (!mvalid_reg || m_ready);
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next = state_reg;
        mvalid_next = mvalid_reg && !m_ready;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (sts.need_tempo) begin
                    state_next = ST_SORT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SORT: begin
                cmd.sort_step = 1'b1;
                if (sts.sort_done) begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                cmd.finish = 1'b1;
                mvalid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // result slot is free when finishing (accept path guarantees it)
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |-> !mvalid_reg)
        else $error("result overwritten");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_EVAL)
        else $error("load did not start evaluation");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.sort_step, cmd.div_step, cmd.finish}))
        else $error("overlapping commands");
endmodule
`default_nettype wire

@@ hdl/dscr_datapath.sv @@
// Datapath for DIN sync clock recovery: config registers, period window,
// counting median select, serial divider, tempo smoothing. Depends on dscr_pkg.
`default_nettype none
module dscr_datapath #(
    parameter int WINDOW = 8,
    parameter int PPQN = 24,
    parameter int TIME_BITS = 48
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [dscr_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  wire logic [dscr_pkg::CfgWidth-1:0]      cfg_data,
    input  wire logic [TIME_BITS-1:0]               in_time,
    input  wire logic [1:0]                         in_opcode,
    input  wire logic                               in_level,
    input  wire dscr_pkg::dscr_cmd_t                cmd,
    output dscr_pkg::dscr_sts_t                     sts,
    output dscr_pkg::out_item_t                     result
);
    import dscr_pkg::*;

    localparam int PW = $clog2(WINDOW);
    localparam int FW = $clog2(WINDOW + 1);
    localparam int DW = 34;           // divide quotient/dividend width
    localparam int DCW = $clog2(DW + 1);
    localparam int DENW = 21 + $clog2(PPQN + 1);
    localparam logic [FW-1:0] WIN_F = FW'(WINDOW);
    localparam logic [4:0] PPQN_C = 5'(PPQN % 32);

    // configuration
    logic        en_reg;
    logic [20:0] min_reg, max_reg;
    logic [3:0]  lock_reg;
    logic [23:0] tmo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg <= 1'b0;
            min_reg <= 21'd1000;
            max_reg <= 21'd2000000;
            lock_reg <= 4'd4;
            tmo_reg <= 24'd2000000;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ENABLE:  en_reg <= cfg_data[0];
                REG_MIN:     min_reg <= cfg_data[20:0];
                REG_MAX:     max_reg <= cfg_data[20:0];
                REG_LOCK:    lock_reg <= cfg_data[3:0];
                REG_TIMEOUT: tmo_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // state
    logic [20:0]          win_reg [WINDOW];
    logic [PW-1:0]        ptr_reg;
    logic [FW-1:0]        fill_reg;
    logic [TIME_BITS-1:0] last_reg;
    logic                 have_reg;
    logic [16:0]          tempo_reg;
    logic                 lock_reg_f, run_reg;
    logic [31:0]          pulse_reg;
    logic [4:0]           phase_reg;

    // per-item working registers
    logic [1:0]           op_reg;
    logic                 lvl_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] delta_reg;
    logic                 act_reg;
    logic                 eval_reg;   // high in the cycle after load
    logic                 stored_reg; // tempo update pending for this edge
    logic [1:0]           ev_reg;
    logic [FW-1:0]        scan_reg;
    logic [DW-1:0]        rem_reg, quo_reg;
    logic [DENW-1:0]      den_reg;
    logic [DCW-1:0]       dcnt_reg;
    logic                 nt_ok_reg;

    // delta of current item against last edge
    logic [TIME_BITS-1:0] delta_c;
    assign delta_c = in_time - last_reg;

    // window classification, computed in EVAL from registered delta
    logic in_range;
    assign in_range = have_reg && (delta_reg > TIME_BITS'(min_reg))
                      && (delta_reg < TIME_BITS'(max_reg));
    logic [FW-1:0] fill_new;
    assign fill_new = (fill_reg < WIN_F) ? fill_reg + 1'b1 : fill_reg;

    logic store_c;
    assign store_c = act_reg && (op_reg == OP_EDGE) && in_range;

    assign sts.need_tempo = store_c && (fill_new >= FW'(2));

    // median by counting: candidate scan_reg is median when
    // #less <= k < #less + #equal, k = fill/2
    logic [FW-1:0] n_less, n_eq, k_med;
    logic [20:0]   cand;
    assign cand = win_reg[scan_reg[PW-1:0]];
    assign k_med = fill_reg >> 1;
    always_comb begin
        n_less = '0;
        n_eq = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (FW'(i) < fill_reg) begin
                if (win_reg[i] < cand) n_less = n_less + 1'b1;
                if (win_reg[i] == cand) n_eq = n_eq + 1'b1;
            end
        end
    end
    logic is_med;
    assign is_med = (n_less <= k_med) && (k_med < n_less + n_eq);
    assign sts.sort_done = is_med;

    // restoring divider, one bit a cycle
    logic [DW:0] rem_sh;
    logic [DW:0] trial;
    assign rem_sh = {rem_reg, quo_reg[DW-1]};
    assign trial = rem_sh - (DW+1)'(den_reg);
    assign sts.div_done = (dcnt_reg == DCW'(1));

    // clamp and smooth
    logic [16:0] nt_cl;
    always_comb begin
        if (!nt_ok_reg) nt_cl = TEMPO_MAX;
        else if (quo_reg < DW'(TEMPO_MIN)) nt_cl = TEMPO_MIN;
        else if (quo_reg > DW'(TEMPO_MAX)) nt_cl = TEMPO_MAX;
        else nt_cl = quo_reg[16:0];
    end
    // divide by ten as multiply by ceil(2^23/10), exact for mix below 2^22
    logic [20:0] mix;
    logic [40:0] prod;
    logic [16:0] smooth;
    assign mix = 21'(tempo_reg) * 21'd9 + 21'(nt_cl);
    assign prod = 41'(mix) * 41'd838861;
    assign smooth = prod[39:23];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) win_reg[i] <= '0;
            ptr_reg <= '0;
            fill_reg <= '0;
            last_reg <= '0;
            have_reg <= 1'b0;
            tempo_reg <= TEMPO_RESET;
            lock_reg_f <= 1'b0;
            run_reg <= 1'b0;
            pulse_reg <= '0;
            phase_reg <= '0;
            ev_reg <= EV_NONE;
            stored_reg <= 1'b0;
            eval_reg <= 1'b0;
        end else begin
            eval_reg <= cmd.load;
            if (cmd.load) begin
                op_reg <= in_opcode;
                lvl_reg <= in_level;
                now_reg <= in_time;
                delta_reg <= delta_c;
                act_reg <= en_reg;
                scan_reg <= '0;
                stored_reg <= 1'b0;
                nt_ok_reg <= 1'b0;
            end
            // EVAL: store an in-range period, note whether tempo follows
            if (eval_reg && store_c) begin
                win_reg[ptr_reg] <= delta_reg[20:0];
                ptr_reg <= (ptr_reg == PW'(WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
                fill_reg <= fill_new;
                stored_reg <= (fill_new >= FW'(2));
            end
            if (cmd.sort_step) begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.div_start) begin
                den_reg <= DENW'(cand) * DENW'(PPQN);
                nt_ok_reg <= (cand != '0);
                rem_reg <= '0;
                quo_reg <= TEMPO_NUM;
                dcnt_reg <= DCW'(DW);
            end else if (cmd.div_step) begin
                if (!trial[DW]) rem_reg <= trial[DW-1:0];
                else rem_reg <= rem_sh[DW-1:0];
                quo_reg <= {quo_reg[DW-2:0], !trial[DW]};
                dcnt_reg <= dcnt_reg - 1'b1;
            end
            if (cmd.finish) begin
                ev_reg <= EV_NONE;
                if (act_reg) begin
                    case (op_reg)
                        OP_EDGE: begin
                            if (stored_reg) begin
                                tempo_reg <= lock_reg_f ? smooth : nt_cl;
                                if (!lock_reg_f && fill_reg >= FW'(lock_reg)
                                    && {1'b0, lock_reg} <= 5'(WINDOW)) begin
                                    lock_reg_f <= 1'b1;
                                    run_reg <= 1'b1;
                                    ev_reg <= EV_LOCK;
                                end
                            end
                            last_reg <= now_reg;
                            have_reg <= 1'b1;
                            pulse_reg <= pulse_reg + 1'b1;
                            // phase restarts with the pulse count at its wrap
                            phase_reg <= (pulse_reg == '1 || phase_reg == PPQN_C - 1'b1
                                          || PPQN == 1) ? 5'd0 : phase_reg + 1'b1;
                        end
                        OP_RUN: begin
                            run_reg <= lvl_reg;
                            if (lvl_reg) begin
                                pulse_reg <= '0;
                                phase_reg <= '0;
                            end
                        end
                        OP_TIMEOUT: begin
                            if (lock_reg_f && delta_reg >= TIME_BITS'(tmo_reg)) begin
                                lock_reg_f <= 1'b0;
                                run_reg <= 1'b0;
                                ev_reg <= EV_LOST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_comb begin
        result.tempo_q8 = tempo_reg;
        result.locked = lock_reg_f;
        result.running = run_reg;
        result.pulse_total = pulse_reg;
        result.phase_step = phase_reg;
        result.event_code = ev_reg;
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= WIN_F)
        else $error("window fill overflow");
    a_lock_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(lock_reg_f) |-> run_reg && ev_reg == EV_LOCK)
        else $error("lock without run");
    a_tempo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tempo_reg >= TEMPO_MIN && tempo_reg <= TEMPO_MAX)
        else $error("tempo out of range");
endmodule
`default_nettype wire

@@ bench/dscr_checker.sv @@
// Result checker for DIN sync clock recovery: watches the input, result and
// register-write ports, predicts each result, compares. Depends on dscr_pkg.
`timescale 1ns / 1ps
module dscr_checker
    import dscr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CfgIdxWidth-1:0] cfg_index,
    input  wire logic [CfgWidth-1:0]    cfg_data,
    input  wire logic                   s_valid,
    input  wire logic                   s_ready,
    input  wire in_item_t               s_data,
    input  wire logic                   m_valid,
    input  wire logic                   m_ready,
    input  wire out_item_t              m_data,
    output int                          fail_count,
    output int                          pending,
    output int                          result_count,
    output int                          lock_events,
    output int                          lost_events
);
    localparam int NWIN = 8;
    localparam int NPPQN = 24;

    // configuration copy
    logic        en_q;
    logic [20:0] min_q, max_q;
    logic [3:0]  lock_q;
    logic [23:0] tmo_q;

    // predicted tempo tracker state
    logic [20:0] periods [NWIN];
    logic [2:0]  wr_ptr;
    logic [3:0]  fill;
    logic [47:0] last_t;
    logic        have_last;
    logic [16:0] tempo;
    logic        lock_st, run_st;
    logic [31:0] pulses;

    out_item_t expected_results[$];

    function automatic logic [16:0] tempo_of(logic [20:0] m);
        logic [63:0] den, t;
        den = 64'(NPPQN) * 64'(m);
        if (den == 0) return TEMPO_MAX;
        t = 64'(TEMPO_NUM) / den;
        if (t < 64'(TEMPO_MIN)) t = 64'(TEMPO_MIN);
        if (t > 64'(TEMPO_MAX)) t = 64'(TEMPO_MAX);
        return t[16:0];
    endfunction

    function automatic logic [20:0] median_period();
        logic [20:0] s [NWIN];
        logic [20:0] v;
        int j;
        for (int i = 0; i < fill; i++) begin
            v = periods[i];
            j = i;
            while (j > 0 && s[j-1] > v) begin
                s[j] = s[j-1];
                j--;
            end
            s[j] = v;
        end
        return s[fill/2];
    endfunction

    // advance the predicted state by one event, return its result
    function automatic out_item_t track_event(in_item_t e);
        out_item_t r;
        logic [1:0]  ev;
        logic [47:0] delta;
        logic [16:0] nt;
        ev = EV_NONE;
        delta = e.timestamp_us - last_t;
        if (en_q) begin
            case (e.opcode)
                OP_EDGE: begin
                    if (have_last && delta > 48'(min_q) && delta < 48'(max_q)) begin
                        periods[wr_ptr] = delta[20:0];
                        wr_ptr = wr_ptr + 3'd1;
                        if (fill < NWIN) fill = fill + 4'd1;
                        if (fill >= 2) begin
                            nt = tempo_of(median_period());
                            if (lock_st)
                                tempo = 17'((9 * 32'(tempo) + 32'(nt)) / 10);
                            else
                                tempo = nt;
                            if (!lock_st && fill >= lock_q) begin
                                lock_st = 1'b1;
                                run_st = 1'b1;
                                ev = EV_LOCK;
                            end
                        end
                    end
                    last_t = e.timestamp_us;
                    have_last = 1'b1;
                    pulses = pulses + 32'd1;
                end
                OP_RUN: begin
                    run_st = e.run_level;
                    if (e.run_level) pulses = '0;
                end
                OP_TIMEOUT: begin
                    if (lock_st && delta >= 48'(tmo_q)) begin
                        lock_st = 1'b0;
                        run_st = 1'b0;
                        ev = EV_LOST;
                    end
                end
                default: ;
            endcase
        end
        r.tempo_q8 = tempo;
        r.locked = lock_st;
        r.running = run_st;
        r.pulse_total = pulses;
        r.phase_step = 5'(pulses % NPPQN);
        r.event_code = ev;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // track, predict and compare at each edge
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            en_q <= 1'b0; min_q <= 21'd1000; max_q <= 21'd2000000;
            lock_q <= 4'd4; tmo_q <= 24'd2000000;
            for (int i = 0; i < NWIN; i++) periods[i] = '0;
            wr_ptr = '0; fill = '0; last_t = '0; have_last = 1'b0;
            tempo = TEMPO_RESET; lock_st = 1'b0; run_st = 1'b0; pulses = '0;
            expected_results.delete();
            fail_count = 0;
            result_count = 0;
            lock_events = 0;
            lost_events = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ENABLE:  en_q <= cfg_data[0];
                    REG_MIN:     min_q <= cfg_data[20:0];
                    REG_MAX:     max_q <= cfg_data[20:0];
                    REG_LOCK:    lock_q <= cfg_data[3:0];
                    REG_TIMEOUT: tmo_q <= cfg_data[23:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) expected_results.push_back(track_event(s_data));
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result transfer", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.event_code == EV_LOCK) lock_events++;
                    if (m_data.event_code == EV_LOST) lost_events++;
                    if (m_data.tempo_q8 !== want.tempo_q8)
                        report_mismatch("tempo_q8", m_data.tempo_q8, want.tempo_q8);
                    if (m_data.locked !== want.locked)
                        report_mismatch("locked", m_data.locked, want.locked);
                    if (m_data.running !== want.running)
                        report_mismatch("running", m_data.running, want.running);
                    if (m_data.pulse_total !== want.pulse_total)
                        report_mismatch("pulse_total", m_data.pulse_total, want.pulse_total);
                    if (m_data.phase_step !== want.phase_step)
                        report_mismatch("phase_step", m_data.phase_step, want.phase_step);
                    if (m_data.event_code !== want.event_code)
                        report_mismatch("event_code", m_data.event_code, want.event_code);
                end
            end
        end
        pending <= expected_results.size();
    end
endmodule

@@ bench/din_sync_clock_recovery_core_tb.sv @@
// Testbench top for DIN sync clock recovery: clock, reset, register writes,
// event stimulus and verdict. Depends on dscr_pkg, dscr_checker, the core.
`timescale 1ns / 1ps
module din_sync_clock_recovery_core_tb;
    import dscr_pkg::*;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CfgIdxWidth-1:0] cfg_index = '0;
    logic [CfgWidth-1:0]    cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    in_item_t               s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    out_item_t              m_data;
    int                     fail_count, pending, result_count, lock_events, lost_events;
    logic                   steady = 1'b0;  // no idling on either side
    logic [47:0]            now_us = '0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    din_sync_clock_recovery_core dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    dscr_checker chk (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending), .result_count(result_count),
        .lock_events(lock_events), .lost_events(lost_events)
    );

    // result side stalls
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 37);
    end

    // one register write, then write enable is taken low again
    task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // one event transfer, with random idle cycles ahead of it unless steady; valid stays
    // high after the transfer until the next event or a drain
    task automatic send_event(logic [1:0] op, logic [47:0] ts, logic lvl);
        in_item_t e;
        while (!steady && $urandom_range(99) < 37) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        e.opcode = op;
        e.timestamp_us = ts;
        e.run_level = lvl;
        s_valid <= 1'b1;
        s_data <= e;
        @(posedge aclk iff s_ready);
    endtask

    // wait until all results arrived and the core has settled
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // edge after a given period, advancing the running clock
    task automatic edge_after(logic [47:0] dt);
        now_us = now_us + dt;
        send_event(OP_EDGE, now_us, 1'b0);
    endtask

    task automatic random_phase(int n, int base_period);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 70)
                edge_after(48'(base_period + $urandom_range(base_period / 8)
                    - base_period / 16));
            else if (r < 76)
                edge_after(48'($urandom_range(3000000)));
            else if (r < 84)
                send_event(OP_RUN, now_us, 1'($urandom));
            else if (r < 94) begin
                now_us = now_us + 48'($urandom_range(3000000));
                send_event(OP_TIMEOUT, now_us, 1'($urandom));
            end else if (r < 97)
                send_event(OP_TIMEOUT, 48'({$urandom, $urandom}), 1'($urandom));
            else
                send_event(OP_UNUSED, 48'({$urandom, $urandom}), 1'($urandom));
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // disabled: events are ignored
        send_event(OP_EDGE, 48'd5000, 1'b1);
        send_event(OP_RUN, 48'd6000, 1'b1);
        drain();

        // directed: defaults, enabled
        write_reg(REG_ENABLE, 24'd1);
        send_event(OP_EDGE, 48'hFFFF_FFFF_F000, 1'b1);
        now_us = 48'hFFFF_FFFF_F000;
        edge_after(48'd20833);           // wraps through zero
        edge_after(48'd20833);
        edge_after(48'd1000);            // on the lower bound, rejected
        edge_after(48'd20000);
        edge_after(48'd21000);           // lock here
        edge_after(48'd1999999);         // longest accepted period
        edge_after(48'd2000000);         // on the upper bound, rejected
        send_event(OP_RUN, now_us, 1'b1);
        send_event(OP_RUN, now_us, 1'b0);
        send_event(OP_TIMEOUT, now_us + 48'd1999999, 1'b0);
        send_event(OP_TIMEOUT, now_us + 48'd2000000, 1'b1);
        send_event(OP_UNUSED, 48'hFFFF_FFFF_FFFF, 1'b1);
        drain();

        // directed: extreme settings, fastest tempo clamp, instant timeout
        write_reg(REG_MIN, 24'd0);
        write_reg(REG_MAX, 24'h1FFFFF);
        write_reg(REG_LOCK, 24'd0);
        write_reg(REG_TIMEOUT, 24'd1);
        edge_after(48'd1);
        edge_after(48'd1);
        edge_after(48'd2097150);
        send_event(OP_TIMEOUT, now_us + 48'd1, 1'b0);
        drain();
        write_reg(REG_LOCK, 24'd15);
        write_reg(REG_TIMEOUT, 24'hFFFFFF);
        for (int i = 0; i < 10; i++) edge_after(48'd30000);
        drain();

        // random phases across settings
        write_reg(REG_MIN, 24'd1000);
        write_reg(REG_MAX, 24'd2000000);
        write_reg(REG_LOCK, 24'd2);
        write_reg(REG_TIMEOUT, 24'd200000);
        steady <= 1'b1;
        random_phase(150, 20833);
        drain();
        steady <= 1'b0;
        write_reg(REG_LOCK, 24'd8);
        write_reg(REG_TIMEOUT, 24'd1500000);
        random_phase(150, 50000);
        drain();
        write_reg(REG_MIN, 24'd100);
        write_reg(REG_MAX, 24'd4000);
        write_reg(REG_LOCK, 24'd3);
        write_reg(REG_TIMEOUT, 24'd0);
        random_phase(150, 2000);
        drain();
        write_reg(REG_MIN, 24'($urandom_range(2000)));
        write_reg(REG_MAX, 24'($urandom_range(2097151)));
        write_reg(REG_LOCK, 24'($urandom_range(8, 2)));
        write_reg(REG_TIMEOUT, 24'($urandom_range(16777215, 1)));
        random_phase(150, 100000);
        drain();
        write_reg(REG_ENABLE, 24'd0);
        random_phase(20, 20000);
        drain();

        $display("Covered %0d results, %0d lock acquisitions, %0d lock losses.",
            result_count, lock_events, lost_events);
        if (fail_count == 0)
            $display("PASS din_sync_clock_recovery_core");
        else
            $display("FAIL din_sync_clock_recovery_core");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL din_sync_clock_recovery_core");
        $finish;
    end
endmodule
